// ----- hw/rtl/lru_pkg.sv -----
// ---------------------------------------------------------------------------
// lru_pkg
// Types and constants shared by the lru frame replacement tracker modules.
// ---------------------------------------------------------------------------
package lru_pkg;

    localparam int FRAME_COUNT = 16;
    localparam int PAGE_BITS   = 20;
    localparam int SLOT_W      = 4;
    localparam int CNT_W       = 5;
    localparam int TOTAL_W     = 32;
    localparam int KIND_W      = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 3'd0,
        KIND_ACCESS = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_VICTIM = 3'd3,
        KIND_CLEAR  = 3'd4
    } t_kind;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [PAGE_BITS-1:0] page_id;
        logic [SLOT_W-1:0]    frame_id;
    } t_in_item;

    typedef struct packed {
        logic               applied;
        logic               victim_valid;
        logic [SLOT_W-1:0]  victim_frame;
        logic [CNT_W-1:0]   tracked_count;
        logic [TOTAL_W-1:0] replacement_count;
    } t_out_item;

    typedef struct packed {
        logic load_item;
        logic lookup;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_hold;
    } t_dp_status;

endpackage

// ----- hw/rtl/lru_ctrl.sv -----
// ---------------------------------------------------------------------------
// lru_ctrl
// Sequencer: accept an event, run the slot lookup, then commit the update.
// ---------------------------------------------------------------------------
module lru_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lru_pkg::t_dp_status i_status,
    output lru_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } t_state;

    t_state r_state, n_state;
    logic   r_busy,  n_busy;

    assign o_in_stall = r_busy;

    always_comb begin
        o_cmd.load_item = i_in_valid && !r_busy;
        o_cmd.lookup    = (r_state == ST_LOOK);
        o_cmd.commit    = (r_state == ST_UPD) && !i_status.out_hold;
    end

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOOK;
                    n_busy  = 1'b1;
                end
            end
            ST_LOOK: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                // wait here while the previous result is still unclaimed
                if (!i_status.out_hold) begin
                    n_state = ST_IDLE;
                    n_busy  = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    a_busy_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != ST_IDLE))
        else $error("busy flag out of step with state");

    a_look_then_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOOK |=> r_state == ST_UPD)
        else $error("lookup not followed by update");

    a_no_commit_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.out_hold |-> !o_cmd.commit)
        else $error("commit while result register is held");

endmodule

// ----- hw/rtl/lru_datapath.sv -----
// ---------------------------------------------------------------------------
// lru_datapath
// Slot table, recency ranks, counters, lookup registers and result register.
// ---------------------------------------------------------------------------
module lru_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lru_pkg::t_dp_cmd    i_cmd,
    output lru_pkg::t_dp_status o_status,
    input  lru_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lru_pkg::t_out_item  o_out_item
);

    lru_pkg::t_in_item r_item;

    logic [lru_pkg::FRAME_COUNT-1:0] r_valid, n_valid;
    logic [lru_pkg::PAGE_BITS-1:0]   r_page [lru_pkg::FRAME_COUNT];
    logic [lru_pkg::SLOT_W-1:0]      r_rec  [lru_pkg::FRAME_COUNT];
    logic [lru_pkg::SLOT_W-1:0]      n_rec  [lru_pkg::FRAME_COUNT];
    logic [lru_pkg::CNT_W-1:0]       r_occ, n_occ;
    logic [lru_pkg::TOTAL_W-1:0]     r_total, n_total;

    // lookup results
    logic                       r_hit, n_hit;
    logic [lru_pkg::SLOT_W-1:0] r_hit_idx, n_hit_idx;
    logic [lru_pkg::SLOT_W-1:0] r_hit_rank;
    logic                       r_vic_valid, n_vic_valid;
    logic [lru_pkg::SLOT_W-1:0] r_vic_idx, n_vic_idx;
    logic                       r_frame_busy;

    lru_pkg::t_out_item r_out_item;
    logic               r_out_valid;

    logic                       applied, vic_valid, acc_match, frame_ok, load_ok;
    logic [lru_pkg::SLOT_W-1:0] vic_frame;
    logic [lru_pkg::CNT_W-1:0]  occ_m1;

    assign o_status.out_hold = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out_item;

    // parallel page compare and rank-zero search; lowest slot wins
    always_comb begin
        n_hit       = 1'b0;
        n_hit_idx   = '0;
        n_vic_valid = 1'b0;
        n_vic_idx   = '0;
        for (int i = lru_pkg::FRAME_COUNT - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_page[i] == r_item.page_id[lru_pkg::PAGE_BITS-1:0])) begin
                n_hit     = 1'b1;
                n_hit_idx = lru_pkg::SLOT_W'(i);
            end
            if (r_valid[i] && (r_rec[i] == '0)) begin
                n_vic_valid = 1'b1;
                n_vic_idx   = lru_pkg::SLOT_W'(i);
            end
        end
    end

    assign frame_ok  = {1'b0, r_item.frame_id} < lru_pkg::CNT_W'(lru_pkg::FRAME_COUNT);
    assign acc_match = r_hit && (r_hit_idx == r_item.frame_id);
    assign load_ok   = frame_ok && !r_hit && !r_frame_busy;
    assign occ_m1    = r_occ - 1'b1;

    always_comb begin
        n_valid   = r_valid;
        n_rec     = r_rec;
        n_occ     = r_occ;
        n_total   = r_total;
        applied   = 1'b0;
        vic_valid = 1'b0;
        vic_frame = '0;
        case (r_item.kind)
            lru_pkg::KIND_LOAD: begin
                if (load_ok) begin
                    n_valid[r_item.frame_id] = 1'b1;
                    n_rec[r_item.frame_id]   = r_occ[lru_pkg::SLOT_W-1:0];
                    n_occ                    = r_occ + 1'b1;
                    applied                  = 1'b1;
                end
            end
            lru_pkg::KIND_ACCESS: begin
                if (acc_match) begin
                    for (int i = 0; i < lru_pkg::FRAME_COUNT; i++) begin
                        if (r_valid[i] && (r_rec[i] > r_hit_rank)) begin
                            n_rec[i] = r_rec[i] - 1'b1;
                        end
                    end
                    n_rec[r_hit_idx] = occ_m1[lru_pkg::SLOT_W-1:0];
                    applied          = 1'b1;
                end
            end
            lru_pkg::KIND_REMOVE: begin
                if (acc_match) begin
                    for (int i = 0; i < lru_pkg::FRAME_COUNT; i++) begin
                        if (r_valid[i] && (r_rec[i] > r_hit_rank)) begin
                            n_rec[i] = r_rec[i] - 1'b1;
                        end
                    end
                    n_valid[r_hit_idx] = 1'b0;
                    n_occ              = occ_m1;
                    applied            = 1'b1;
                end
            end
            lru_pkg::KIND_VICTIM: begin
                if (r_vic_valid) begin
                    vic_valid = 1'b1;
                    vic_frame = r_vic_idx;
                    n_total   = r_total + 1'b1;
                    applied   = 1'b1;
                end
            end
            lru_pkg::KIND_CLEAR: begin
                n_valid = '0;
                n_occ   = '0;
                n_total = '0;
                applied = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
        if (i_cmd.lookup) begin
            r_hit        <= n_hit;
            r_hit_idx    <= n_hit_idx;
            r_hit_rank   <= r_rec[n_hit_idx];
            r_vic_valid  <= n_vic_valid;
            r_vic_idx    <= n_vic_idx;
            r_frame_busy <= r_valid[r_item.frame_id];
        end
        if (i_cmd.commit) begin
            r_rec <= n_rec;
            if ((r_item.kind == lru_pkg::KIND_LOAD) && load_ok) begin
                r_page[r_item.frame_id] <= r_item.page_id[lru_pkg::PAGE_BITS-1:0];
            end
            r_out_item.applied           <= applied;
            r_out_item.victim_valid      <= vic_valid;
            r_out_item.victim_frame      <= vic_frame;
            r_out_item.tracked_count     <= n_occ;
            r_out_item.replacement_count <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_occ       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_valid <= n_valid;
                r_occ   <= n_occ;
                r_total <= n_total;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= lru_pkg::CNT_W'(lru_pkg::FRAME_COUNT))
        else $error("occupancy beyond frame count");

    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lru_pkg::CNT_W'($countones(r_valid)) == r_occ)
        else $error("occupancy differs from number of valid slots");

    a_commit_sets_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid && (r_out_item.tracked_count == r_occ))
        else $error("result register not loaded after commit");

endmodule

// ----- hw/rtl/lru_frame_replacement_tracker_unit.sv -----
// ---------------------------------------------------------------------------
// lru_frame_replacement_tracker_unit
// LRU page and frame pairing tracker with victim selection.
// ---------------------------------------------------------------------------
// Each event passes these steps from input to result: the transfer, in which
// it is registered; a lookup step, in which all sixteen slots are compared
// against the page and searched for the rank-zero slot; and an update step,
// in which the slot table, ranks and counters are updated and the result
// register is loaded. The controller runs these steps over the one slot
// table, so no new event is taken before the last is updated; a new event is
// taken while the previous result still sits in the result register, and
// the update step waits only while that register is held by i_out_stall.
// Reset empties the table at once, with no clearing pass.
module lru_frame_replacement_tracker_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lru_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lru_pkg::t_out_item o_out_item
);

    lru_pkg::t_dp_cmd    cmd;
    lru_pkg::t_dp_status status;

    lru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lru_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
